>>> hdl/keyframe_linear_interpolator_top_assert.svh
// Assertion macros used by the interpolator checker
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, ignored during reset
`define KFLI_AST_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interpolator check failed");

// next-cycle implication, ignored during reset
`define KFLI_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interpolator check failed");

// next-cycle implication, checked through reset as well
`define KFLI_AST_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("interpolator check failed");

`endif

>>> hdl/kfli_pkg.sv
// Types, constants and codes for the keyframe interpolator
package kfli_pkg;

  localparam int KEY_SLOTS = 64;
  localparam int IW        = $clog2(KEY_SLOTS);
  localparam int CW        = IW + 1;

  localparam int TW  = 32;
  localparam int FW  = 17;
  localparam int MW  = TW + FW;

  localparam logic [FW-1:0] ONE_Q16  = FW'(65536);
  localparam logic [TW-1:0] MAX_TIME = '1;

  // shared divider: 50-bit dividend, 33-bit divisor
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int MUL_AW = 18;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] REG_DURATION  = 2'd0;
  localparam logic [1:0] REG_RANGE_MIN = 2'd1;
  localparam logic [1:0] REG_RANGE_MAX = 2'd2;
  localparam logic [1:0] REG_DEFAULT   = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [31:0]       time_ms;
    logic signed [31:0] key_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [MW-1:0] wdata;
    logic [IW-1:0] raddr;
  } tbl_req_t;

endpackage

>>> hdl/kfli_table.sv
// Keyframe store: time and fraction per slot, one write and one registered read port
module kfli_table import kfli_pkg::*; (
  input  logic          clk,
  input  tbl_req_t      req,
  output logic [MW-1:0] rd_data
);

  logic [MW-1:0] mem [KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

>>> hdl/kfli_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes
module kfli_div import kfli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NW-1]};
    diff    = trial - {1'b0, den_r};
    quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
    rem_nxt = trial[DIV_DW-1:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = diff[DIV_DW-1:0];
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> hdl/keyframe_linear_interpolator_top.sv
// Keyframe linear interpolator: sequencer, config registers, shared multiplier
//
//  channel | ports                       | payload
//  input   | in_valid / in_ready         | in_data  (operation, time_ms, key_value)
//  result  | out_valid / out_ready       | out_data (value, status)
//  config  | cfg_we, cfg_index           | cfg_wdata
//
// One request at a time. Clear, unused op and full-table insert go straight to the
// result. Insert runs a normalising divide on the 50-step divider, then scans the
// stored keys and shifts later keys up; a flat range skips the divide. Sample between
// keys searches segments from the cached index, then multiplies and divides; at the
// first or last key no divide is run; empty table runs the normalising divide only.
// Synchronous active-low reset; the table itself is not cleared.
// A finished result waits in the output register; the next request is taken
// while it waits, and only completion stalls on a full output register.
module keyframe_linear_interpolator_top import kfli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [21:0] {
    ST_IDLE      = 22'h000001,
    ST_NORM_GO   = 22'h000002,
    ST_NORM_WAIT = 22'h000004,
    ST_INS_RD    = 22'h000008,
    ST_INS_CHK   = 22'h000010,
    ST_MV_RD     = 22'h000020,
    ST_MV_WR     = 22'h000040,
    ST_INS_WR    = 22'h000080,
    ST_SMP_RD0   = 22'h000100,
    ST_SMP_CHK0  = 22'h000200,
    ST_SMP_RDL   = 22'h000400,
    ST_SMP_CHKL  = 22'h000800,
    ST_SRC_RDP   = 22'h001000,
    ST_SRC_CHKP  = 22'h002000,
    ST_SRC_RD    = 22'h004000,
    ST_SRC_CHK   = 22'h008000,
    ST_IMUL      = 22'h010000,
    ST_IDIV_GO   = 22'h020000,
    ST_IDIV_WAIT = 22'h040000,
    ST_SCL_MUL   = 22'h080000,
    ST_SCL_FIN   = 22'h100000,
    ST_DONE      = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]        duration_r;
  logic signed [31:0] range_min_r, range_max_r, default_r;

  logic [1:0]         op_r, op_nxt;
  logic [TW-1:0]      t_r, t_nxt;
  logic signed [31:0] kv_r, kv_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [FW-1:0]      frac_r, frac_nxt;
  logic [TW-1:0]      prev_t_r, prev_t_nxt, cur_t_r, cur_t_nxt;
  logic [FW-1:0]      prev_f_r, prev_f_nxt, cur_f_r, cur_f_nxt, last_f_r, last_f_nxt;
  logic               neg_r, neg_nxt;
  logic               status_r, status_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      cidx_r, cidx_nxt;
  logic [TW-1:0]      ctime_r, ctime_nxt;
  logic               out_valid_r;
  out_t               out_r;

  logic signed [MUL_PW-1:0] mul_r;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;

  tbl_req_t      tbl;
  logic [MW-1:0] rd_data;
  logic [TW-1:0] rd_t;
  logic [FW-1:0] rd_f;
  div_req_t      div_q;
  div_rsp_t      div_s;

  kfli_table u_table (.clk(clk), .req(tbl), .rd_data(rd_data));
  kfli_div   u_div   (.clk(clk), .rst_n(rst_n), .req(div_q), .rsp(div_s));

  assign rd_t = rd_data[MW-1:FW];
  assign rd_f = rd_data[FW-1:0];

  // range arithmetic, 33-bit signed
  logic signed [32:0] span33, norm_num;
  logic [32:0]        span_mag, num_mag;
  logic signed [31:0] norm_v;
  logic [CW-1:0]      last_c;
  logic [IW-1:0]      start_i;
  logic [TW-1:0]      t_eff;
  logic signed [MUL_PW-1:0] mul_mag, p_adj;
  logic [TW-1:0]      seg_span;
  logic signed [MUL_AW-1:0] q_s;
  logic [MUL_AW-1:0]  f_sum;
  logic               out_load;

  always_comb begin
    span33   = 33'(range_max_r) - 33'(range_min_r);
    norm_v   = (op_r == OP_INSERT) ? kv_r : default_r;
    norm_num = 33'(norm_v) - 33'(range_min_r);
    span_mag = span33[32] ? 33'(-span33) : 33'(span33);
    num_mag  = norm_num[32] ? 33'(-norm_num) : 33'(norm_num);
    last_c   = count_r - CW'(1);
    start_i  = (t_r >= ctime_r) ? cidx_r : IW'(1);
    if (start_i == '0 || CW'(start_i) > last_c) begin
      start_i = IW'(1);
    end
    mul_mag  = mul_r[MUL_PW-1] ? -mul_r : mul_r;
    p_adj    = mul_r + (mul_r[MUL_PW-1] ? MUL_PW'(65535) : MUL_PW'(0));
    seg_span = cur_t_r - prev_t_r;
    q_s      = neg_r ? -$signed(div_s.quo[MUL_AW-1:0]) : $signed(div_s.quo[MUL_AW-1:0]);
    f_sum    = MUL_AW'({1'b0, prev_f_r}) + MUL_AW'(q_s);
  end

  // shared multiplier operands
  always_comb begin
    if (state_r == ST_IMUL) begin
      mul_a = $signed(MUL_AW'({1'b0, cur_f_r}) - MUL_AW'({1'b0, prev_f_r}));
      mul_b = $signed({2'b00, t_r - prev_t_r});
    end else begin
      mul_a = $signed({1'b0, frac_r});
      mul_b = MUL_BW'(span33);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IMUL || state_r == ST_SCL_MUL) begin
      mul_r <= mul_a * mul_b;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    t_nxt      = t_r;
    kv_nxt     = kv_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    frac_nxt   = frac_r;
    prev_t_nxt = prev_t_r;
    prev_f_nxt = prev_f_r;
    cur_t_nxt  = cur_t_r;
    cur_f_nxt  = cur_f_r;
    last_f_nxt = last_f_r;
    neg_nxt    = neg_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    count_nxt  = count_r;
    cidx_nxt   = cidx_r;
    ctime_nxt  = ctime_r;
    t_eff      = t_r;
    tbl.we     = 1'b0;
    tbl.waddr  = pos_r[IW-1:0];
    tbl.wdata  = {t_r, frac_r};
    tbl.raddr  = i_r;
    div_q.start = 1'b0;
    div_q.num   = DIV_NW'({num_mag, 16'h0000});
    div_q.den   = span_mag;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          kv_nxt     = in_data.key_value;
          t_nxt      = in_data.time_ms;
          status_nxt = 1'b0;
          value_nxt  = '0;
          i_nxt      = '0;
          pos_nxt    = '0;
          state_nxt  = ST_DONE;
          case (in_data.operation)
            OP_CLEAR: begin
              count_nxt = '0;
              cidx_nxt  = IW'(1);
              ctime_nxt = '0;
            end
            OP_INSERT: begin
              if (count_r == CW'(KEY_SLOTS)) begin
                status_nxt = 1'b1;
              end else begin
                state_nxt = ST_NORM_GO;
              end
            end
            OP_SAMPLE: begin
              if (in_data.time_ms > duration_r) begin
                t_nxt = duration_r;
              end
              state_nxt = (count_r == '0) ? ST_NORM_GO : ST_SMP_RD0;
            end
            default: ;
          endcase
        end
      end
      ST_NORM_GO: begin
        if (span33 == '0) begin
          frac_nxt  = '0;
          state_nxt = (op_r == OP_SAMPLE) ? ST_SCL_MUL :
                      (count_r == '0) ? ST_INS_WR : ST_INS_RD;
        end else begin
          div_q.start = 1'b1;
          neg_nxt     = norm_num[32] ^ span33[32];
          state_nxt   = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        if (div_s.done) begin
          if (neg_r) begin
            frac_nxt = '0;
          end else if (div_s.quo > DIV_NW'(ONE_Q16)) begin
            frac_nxt = ONE_Q16;
          end else begin
            frac_nxt = div_s.quo[FW-1:0];
          end
          state_nxt = (op_r == OP_SAMPLE) ? ST_SCL_MUL :
                      (count_r == '0) ? ST_INS_WR : ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        tbl.raddr = i_r;
        state_nxt = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        // equal time nudges the candidate one tick later
        if (rd_t == t_r) begin
          t_eff = t_r + TW'(1);
        end
        t_nxt = t_eff;
        if (rd_t < t_eff) begin
          pos_nxt = CW'(i_r) + CW'(1);
        end
        if (rd_t == t_r && t_r == MAX_TIME) begin
          status_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else if (CW'(i_r) == last_c) begin
          j_nxt     = count_r;
          state_nxt = (count_r > ((rd_t < t_eff) ? CW'(i_r) + CW'(1) : pos_r)) ?
                      ST_MV_RD : ST_INS_WR;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_INS_RD;
        end
      end
      ST_MV_RD: begin
        tbl.raddr = IW'(j_r - CW'(1));
        state_nxt = ST_MV_WR;
      end
      ST_MV_WR: begin
        tbl.we    = 1'b1;
        tbl.waddr = j_r[IW-1:0];
        tbl.wdata = rd_data;
        j_nxt     = j_r - CW'(1);
        state_nxt = ((j_r - CW'(1)) > pos_r) ? ST_MV_RD : ST_INS_WR;
      end
      ST_INS_WR: begin
        tbl.we    = 1'b1;
        tbl.waddr = pos_r[IW-1:0];
        tbl.wdata = {t_r, frac_r};
        count_nxt = count_r + CW'(1);
        cidx_nxt  = IW'(1);
        ctime_nxt = '0;
        state_nxt = ST_DONE;
      end
      ST_SMP_RD0: begin
        tbl.raddr = '0;
        state_nxt = ST_SMP_CHK0;
      end
      ST_SMP_CHK0: begin
        if (t_r <= rd_t) begin
          frac_nxt  = rd_f;
          state_nxt = ST_SCL_MUL;
        end else begin
          state_nxt = ST_SMP_RDL;
        end
      end
      ST_SMP_RDL: begin
        tbl.raddr = last_c[IW-1:0];
        state_nxt = ST_SMP_CHKL;
      end
      ST_SMP_CHKL: begin
        last_f_nxt = rd_f;
        if (t_r >= rd_t) begin
          frac_nxt  = rd_f;
          state_nxt = ST_SCL_MUL;
        end else begin
          i_nxt     = start_i;
          state_nxt = ST_SRC_RDP;
        end
      end
      ST_SRC_RDP: begin
        tbl.raddr = i_r - IW'(1);
        state_nxt = ST_SRC_CHKP;
      end
      ST_SRC_CHKP: begin
        prev_t_nxt = rd_t;
        prev_f_nxt = rd_f;
        state_nxt  = ST_SRC_RD;
      end
      ST_SRC_RD: begin
        tbl.raddr = i_r;
        state_nxt = ST_SRC_CHK;
      end
      ST_SRC_CHK: begin
        if (rd_t >= t_r) begin
          cur_t_nxt = rd_t;
          cur_f_nxt = rd_f;
          cidx_nxt  = i_r;
          ctime_nxt = t_r;
          state_nxt = ST_IMUL;
        end else if (CW'(i_r) >= last_c) begin
          frac_nxt  = last_f_r;
          state_nxt = ST_SCL_MUL;
        end else begin
          prev_t_nxt = rd_t;
          prev_f_nxt = rd_f;
          i_nxt      = i_r + IW'(1);
          state_nxt  = ST_SRC_RD;
        end
      end
      ST_IMUL: begin
        state_nxt = ST_IDIV_GO;
      end
      ST_IDIV_GO: begin
        div_q.start = 1'b1;
        div_q.num   = mul_mag[DIV_NW-1:0];
        div_q.den   = {1'b0, seg_span};
        neg_nxt     = mul_r[MUL_PW-1];
        state_nxt   = ST_IDIV_WAIT;
      end
      ST_IDIV_WAIT: begin
        if (div_s.done) begin
          frac_nxt  = f_sum[FW-1:0];
          state_nxt = ST_SCL_MUL;
        end
      end
      ST_SCL_MUL: begin
        state_nxt = ST_SCL_FIN;
      end
      ST_SCL_FIN: begin
        // truncate toward zero on the divide by 2^16
        value_nxt = range_min_r + $signed(p_adj[47:16]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cidx_r      <= IW'(1);
      ctime_r     <= '0;
      out_valid_r <= 1'b0;
      duration_r  <= 32'd1000;
      range_min_r <= '0;
      range_max_r <= 32'sd65536;
      default_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cidx_r  <= cidx_nxt;
      ctime_r <= ctime_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DURATION:  duration_r  <= cfg_wdata;
          REG_RANGE_MIN: range_min_r <= cfg_wdata;
          REG_RANGE_MAX: range_max_r <= cfg_wdata;
          REG_DEFAULT:   default_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    t_r      <= t_nxt;
    kv_r     <= kv_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pos_r    <= pos_nxt;
    frac_r   <= frac_nxt;
    prev_t_r <= prev_t_nxt;
    prev_f_r <= prev_f_nxt;
    cur_t_r  <= cur_t_nxt;
    cur_f_r  <= cur_f_nxt;
    last_f_r <= last_f_nxt;
    neg_r    <= neg_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    if (out_load) begin
      out_r.value  <= value_r;
      out_r.status <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/kfli_checker.sv
// Port-level checks for the keyframe interpolator, bound to the top level
`include "keyframe_linear_interpolator_top_assert.svh"

module kfli_checker import kfli_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // one request in flight: busy right after taking one
  `KFLI_AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a dropped insert never carries a value
  `KFLI_AST_IMPLY(a_status_no_value, out_valid && out_data.status, out_data.value == '0)
  // pending result holds
  `KFLI_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // nothing pending after reset
  `KFLI_AST_NEXT_RST(a_reset_empty, !rst_n, !out_valid && in_ready)

endmodule

bind keyframe_linear_interpolator_top kfli_checker u_kfli_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
